// ===== rtl/core/bks_pkg.sv =====
// Shared types and constants for the bracket key substitution block.
package bks_pkg;

  typedef enum logic [1:0] {
    OP_TEXT    = 2'd0,
    OP_KEY_WR  = 2'd1,
    OP_VAL_WR  = 2'd2,
    OP_LEN_WR  = 2'd3
  } op_t;

  localparam logic [7:0] OPEN_MARK    = 8'h28;
  localparam logic [7:0] CLOSE_MARK   = 8'h29;
  localparam logic [7:0] UNKNOWN_MARK = 8'h3F;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic       text_end;
    logic [5:0] entry;
    logic [3:0] char_pos;
    logic [3:0] key_length;
    logic [3:0] value_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic rd_key;
    logic next_idx;
    logic val_start;
    logic rd_val;
    logic next_j;
    logic emit_unk;
    logic emit_val;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic eval;
    logic at_end;
    logic hit;
    logic vlen_zero;
    logic val_last;
    logic slot_free;
  } stat_t;

endpackage

// ===== rtl/core/bks_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/bks_ctrl.sv =====
// Sequencer for key search and value emission.
module bks_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  bks_pkg::stat_t  st,
  output logic            in_ready,
  output bks_pkg::cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_VRD,
    S_VOUT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE) && st.slot_free;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && st.eval) state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        if (st.at_end) begin
          if (st.slot_free) begin
            cmd.emit_unk = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.rd_key = 1'b1;
          state_nxt  = S_CMP;
        end
      end
      S_CMP: begin
        if (st.hit) begin
          cmd.val_start = 1'b1;
          state_nxt     = st.vlen_zero ? S_IDLE : S_VRD;
        end else begin
          cmd.next_idx = 1'b1;
          state_nxt    = S_SEARCH;
        end
      end
      S_VRD: begin
        cmd.rd_val = 1'b1;
        state_nxt  = S_VOUT;
      end
      S_VOUT: begin
        if (st.slot_free) begin
          cmd.emit_val = 1'b1;
          if (st.val_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.next_j = 1'b1;
            state_nxt  = S_VRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/bks_dp.sv =====
// Datapath: key collection, table memories, search compare and output register.
module bks_dp #(
  parameter int ENTRIES     = 64,
  parameter int KEY_CHARS   = 10,
  parameter int VALUE_CHARS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  bks_pkg::in_item_t   in_data,
  input  logic                cfg_fire,
  input  logic [6:0]          cfg_data,
  input  bks_pkg::cmd_t       cmd,
  output bks_pkg::stat_t      st,
  output logic                out_valid,
  input  logic                out_ready,
  output bks_pkg::out_item_t  out_data
);

  localparam int EW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int IW  = $clog2(ENTRIES + 1);
  localparam int KCW = $clog2(KEY_CHARS + 1);
  localparam int VCW = $clog2(VALUE_CHARS + 1);
  localparam int VD  = ENTRIES * VALUE_CHARS;
  localparam int VAW = (VD > 1) ? $clog2(VD) : 1;

  logic            inside_r;
  logic [KCW-1:0]  key_count_r;
  logic            overlong_r;
  logic [7:0]      key_buf_r [KEY_CHARS];
  logic [IW-1:0]   limit_r;
  logic [IW-1:0]   idx_r;
  logic [VCW-1:0]  vlen_r;
  logic [VCW-1:0]  j_r;
  logic            out_valid_r;
  bks_pkg::out_item_t out_data_r;

  logic is_open, is_close, is_text, entry_ok, pass, append;
  logic [EW-1:0]  waddr, raddr;
  logic [KCW-1:0] klen_sat;
  logic [VCW-1:0] vlen_sat;
  logic [KCW+VCW-1:0] len_rd;
  logic [7:0]     key_rd [KEY_CHARS];
  logic [7:0]     val_rd;
  logic [VAW-1:0] val_waddr, val_raddr;
  logic           mismatch;
  logic           len_we, val_we;

  assign is_open  = in_data.ch == bks_pkg::OPEN_MARK;
  assign is_close = in_data.ch == bks_pkg::CLOSE_MARK;
  assign is_text  = in_data.op == bks_pkg::OP_TEXT;
  assign entry_ok = 32'(in_data.entry) < ENTRIES;
  assign pass     = in_fire && is_text && !inside_r && !is_open;
  assign append   = in_fire && is_text && inside_r && !is_close;

  assign waddr = EW'(in_data.entry);
  assign raddr = EW'(idx_r);

  assign klen_sat = (32'(in_data.key_length) > KEY_CHARS) ? KCW'(KEY_CHARS)
                                                           : KCW'(in_data.key_length);
  assign vlen_sat = (32'(in_data.value_length) > VALUE_CHARS) ? VCW'(VALUE_CHARS)
                                                               : VCW'(in_data.value_length);

  assign len_we = in_fire && (in_data.op == bks_pkg::OP_LEN_WR) && entry_ok;
  assign val_we = in_fire && (in_data.op == bks_pkg::OP_VAL_WR) && entry_ok
                  && (32'(in_data.char_pos) < VALUE_CHARS);
  assign val_waddr = VAW'(in_data.entry) * VAW'(VALUE_CHARS) + VAW'(in_data.char_pos);
  assign val_raddr = VAW'(idx_r) * VAW'(VALUE_CHARS) + VAW'(j_r);

  bks_ram #(.WIDTH(KCW + VCW), .DEPTH(ENTRIES)) u_len_ram (
    .clk(clk), .we(len_we), .waddr(waddr), .wdata({klen_sat, vlen_sat}),
    .re(cmd.rd_key), .raddr(raddr), .rdata(len_rd)
  );

  // One key RAM per character position: all characters of a key are read together.
  for (genvar k = 0; k < KEY_CHARS; k++) begin : g_key
    logic kwe;
    assign kwe = in_fire && (in_data.op == bks_pkg::OP_KEY_WR) && entry_ok
                 && (32'(in_data.char_pos) == k);
    bks_ram #(.WIDTH(8), .DEPTH(ENTRIES)) u_key_ram (
      .clk(clk), .we(kwe), .waddr(waddr), .wdata(in_data.ch),
      .re(cmd.rd_key), .raddr(raddr), .rdata(key_rd[k])
    );
  end

  bks_ram #(.WIDTH(8), .DEPTH(VD)) u_val_ram (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(in_data.ch),
    .re(cmd.rd_val), .raddr(val_raddr), .rdata(val_rd)
  );

  always_comb begin
    mismatch = 1'b0;
    for (int k = 0; k < KEY_CHARS; k++) begin
      if ((32'(key_count_r) > k) && (key_rd[k] != key_buf_r[k])) mismatch = 1'b1;
    end
  end

  always_comb begin
    st.eval      = is_text && (inside_r ? (is_close || in_data.text_end)
                                        : (is_open && in_data.text_end));
    st.at_end    = (idx_r == limit_r) || overlong_r;
    st.hit       = (len_rd[KCW+VCW-1:VCW] == key_count_r) && !mismatch;
    st.vlen_zero = len_rd[VCW-1:0] == '0;
    st.val_last  = (j_r + VCW'(1)) == vlen_r;
    st.slot_free = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r    <= 1'b0;
      key_count_r <= '0;
      overlong_r  <= 1'b0;
      limit_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_fire) begin
        limit_r <= (32'(cfg_data) > ENTRIES) ? IW'(ENTRIES) : IW'(cfg_data);
      end
      if (in_fire && is_text) begin
        if (!inside_r && is_open) begin
          inside_r    <= !in_data.text_end;
          key_count_r <= '0;
          overlong_r  <= 1'b0;
        end else if (inside_r) begin
          if (is_close || in_data.text_end) inside_r <= 1'b0;
          if (!is_close) begin
            if (32'(key_count_r) < KEY_CHARS) key_count_r <= key_count_r + KCW'(1);
            else overlong_r <= 1'b1;
          end
        end
      end
      if (pass || cmd.emit_unk || cmd.emit_val) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < KEY_CHARS; k++) begin
      if (append && (32'(key_count_r) == k)) key_buf_r[k] <= in_data.ch;
    end
    if (in_fire && st.eval) begin
      idx_r <= '0;
    end else if (cmd.next_idx) begin
      idx_r <= idx_r + IW'(1);
    end
    if (cmd.val_start) begin
      vlen_r <= len_rd[VCW-1:0];
      j_r    <= '0;
    end else if (cmd.next_j) begin
      j_r <= j_r + VCW'(1);
    end
    if (pass) begin
      out_data_r <= '{out_char: in_data.ch, run_last: 1'b1};
    end else if (cmd.emit_unk) begin
      out_data_r <= '{out_char: bks_pkg::UNKNOWN_MARK, run_last: 1'b1};
    end else if (cmd.emit_val) begin
      out_data_r <= '{out_char: val_rd, run_last: st.val_last};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/bracket_key_substitution_top.sv =====
// Top level of the bracket key substitution block.
// Channels: in_* takes requests (text characters or table loads), out_* gives
// emitted characters with run_last on the last one caused by a request, and
// cfg_* writes entries_in_use (always ready).
// Load the table (ops 1 to 3) and entries_in_use before sending text.
// Plain text: a request is accepted, its character appears on out_* the next
// cycle; with the receiver ready a new request is taken every cycle.
// A close bracket (or text_end inside a key, or an open bracket with text_end)
// starts a search that visits table entries in turn through the key and length
// memories, then reads and emits value characters in turn from the value memory.
// Hit on an entry with a non-empty value: its characters appear on out_* in
// order, run_last on the last; an empty value emits nothing.
// Miss (all entries in use visited, or key overlong): '?' appears on out_*.
// in_ready is low for the whole search and emission.
// Reset (synchronous, rst_n low) closes any open key, empties the output
// register and zeroes entries_in_use; table contents are kept as garbage and
// must be loaded before use.
// When the receiver stalls, the output register holds its character and
// in_ready drops until the slot frees.
module bracket_key_substitution_top #(
  parameter int ENTRIES     = 64,
  parameter int KEY_CHARS   = 10,
  parameter int VALUE_CHARS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bks_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bks_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data
);

  bks_pkg::cmd_t  cmd;
  bks_pkg::stat_t st;
  logic in_fire;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  bks_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .st(st),
    .in_ready(in_ready), .cmd(cmd)
  );

  bks_dp #(.ENTRIES(ENTRIES), .KEY_CHARS(KEY_CHARS), .VALUE_CHARS(VALUE_CHARS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_data(in_data),
    .cfg_fire(cfg_valid && cfg_ready), .cfg_data(cfg_data),
    .cmd(cmd), .st(st), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

endmodule

// ===== rtl/core/bks_checker.sv =====
// Port-level checks for the bracket key substitution top, bound to it.
module bks_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input bks_pkg::out_item_t out_data,
  input logic               cfg_ready
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_ready_slot: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!out_valid || out_ready))
    else $error("request taken while output slot is blocked");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("output changed while stalled");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");

endmodule

bind bracket_key_substitution_top bks_checker u_bks_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_data(out_data), .cfg_ready(cfg_ready)
);
